// ===== rtl/buddy_block_allocator_macros.svh =====
// ---------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shorthand for the clocked, reset-gated properties used by the checker.
// ---------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bba_pkg.sv =====
// ---------------------------------------------------------------------------
// Buddy block allocator package
// Sizes, codes, item types and order clamping shared by the block files.
// ---------------------------------------------------------------------------
package bba_pkg;

	localparam int LEVELS     = 11;
	localparam int LIST_DEPTH = 1024;
	localparam int ORD_LIMIT  = 40;

	localparam int ORD_W   = 6;
	localparam int SIZE_W  = 41;
	localparam int OFF_W   = 40;
	localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int LEN_W   = $clog2(LIST_DEPTH + 1);
	localparam int ENTRY_W = (LEVELS > 1) ? LEVELS - 1 : 1;
	localparam int MEM_DEPTH = LEVELS * LIST_DEPTH;
	localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam logic [ORD_W-1:0] LO_ORD_RST     = 6'd6;
	localparam logic [ORD_W-1:0] POOL_ORDER_RST = 6'd16;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_NO_SPACE  = 2'd2;

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_LO_ORD     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_ORDER = 8'd1;

	typedef struct packed {
		logic              command;
		logic [SIZE_W-1:0] request_size;
		logic [OFF_W-1:0]  block_offset;
		logic [ORD_W-1:0]  block_order;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [OFF_W-1:0]  granted_offset;
		logic [ORD_W-1:0]  granted_order;
		logic [SIZE_W-1:0] bytes_in_use;
	} rsp_t;

	function automatic logic [ORD_W-1:0] eff_min(input logic [ORD_W-1:0] m);
		return (m > ORD_W'(ORD_LIMIT)) ? ORD_W'(ORD_LIMIT) : m;
	endfunction

	function automatic logic [ORD_W-1:0] eff_pool(input logic [ORD_W-1:0] m_raw,
		input logic [ORD_W-1:0] p_raw);
		logic [ORD_W:0] m;
		logic [ORD_W:0] p;
		logic [ORD_W:0] lim;
		m   = {1'b0, eff_min(m_raw)};
		p   = {1'b0, p_raw};
		lim = m + (ORD_W+1)'(LEVELS - 1);
		if (p > lim) p = lim;
		if (p > (ORD_W+1)'(ORD_LIMIT)) p = (ORD_W+1)'(ORD_LIMIT);
		if (p < m) p = m;
		return p[ORD_W-1:0];
	endfunction

endpackage

// ===== rtl/buddy_block_allocator.sv =====
// ---------------------------------------------------------------------------
// Buddy block allocator
// One pool, one FIFO free list per order in a single RAM, run by a sequencer.
// ---------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_stall | bba_pkg::req_t (command, size, offset, order)
//  rsp     | out | rsp_valid/rsp_stall | bba_pkg::rsp_t (status, grant, bytes in use)
//  cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (smallest order, pool order)
//
// One item at a time; the free-list RAM (one read, one write port) sets the pace.
// Alloc: round the size up, walk up to a non-empty list, take its head, split down.
// Free: check, search each level's list for the buddy, remove it and merge, then append.
// Reset or a register write: the init state seeds the top list, no item taken.
// A finished result waits in the output register; the next item is taken meanwhile.
module buddy_block_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  bba_pkg::req_t                     req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output bba_pkg::rsp_t                     rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bba_pkg::ORD_W-1:0]         cfg_data
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_INIT   = 4'd1;
	localparam logic [3:0] S_A_ORD  = 4'd2;
	localparam logic [3:0] S_A_CHK  = 4'd3;
	localparam logic [3:0] S_A_FIND = 4'd4;
	localparam logic [3:0] S_A_HEAD = 4'd5;
	localparam logic [3:0] S_RM_RD  = 4'd6;
	localparam logic [3:0] S_RM_WR  = 4'd7;
	localparam logic [3:0] S_SPLIT  = 4'd8;
	localparam logic [3:0] S_F_CHK  = 4'd9;
	localparam logic [3:0] S_F_LVL  = 4'd10;
	localparam logic [3:0] S_F_RD   = 4'd11;
	localparam logic [3:0] S_F_CMP  = 4'd12;
	localparam logic [3:0] S_F_APP  = 4'd13;
	localparam logic [3:0] S_DONE   = 4'd14;

	localparam int ORD_W   = bba_pkg::ORD_W;
	localparam int SIZE_W  = bba_pkg::SIZE_W;
	localparam int OFF_W   = bba_pkg::OFF_W;
	localparam int LVL_W   = bba_pkg::LVL_W;
	localparam int IDX_W   = bba_pkg::IDX_W;
	localparam int LEN_W   = bba_pkg::LEN_W;
	localparam int ENTRY_W = bba_pkg::ENTRY_W;
	localparam int ADDR_W  = bba_pkg::ADDR_W;

	logic [3:0]          state_q;
	logic [ORD_W-1:0]    min_q, pool_q;
	logic [LEN_W-1:0]    len_q [bba_pkg::LEVELS];
	logic [SIZE_W-1:0]   used_q;
	logic                cmd_q;
	logic [SIZE_W-1:0]   req_q;
	logic [OFF_W-1:0]    off_q;
	logic [ORD_W-1:0]    ord_q, tgt_q;
	logic [ENTRY_W-1:0]  v_q;
	logic [LEN_W-1:0]    idx_q;
	logic [1:0]          st_q;
	logic [OFF_W-1:0]    goff_q;
	logic [ORD_W-1:0]    gord_q;
	logic                rsp_valid_q;
	bba_pkg::rsp_t       rsp_q;

	logic [ENTRY_W-1:0]  mem [bba_pkg::MEM_DEPTH];
	logic [ENTRY_W-1:0]  rdata_q;
	logic                mem_we, mem_re;
	logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0]  mem_wdata;

	logic [ORD_W-1:0]    m_eff, p_eff;
	logic [SIZE_W-1:0]   cap, free_bytes;
	logic [LVL_W-1:0]    lvl, lvl_dn, len_sel, top_lvl;
	logic [LEN_W-1:0]    len_cur;
	logic                len_room;
	logic [LEN_W:0]      idx_nx;
	logic [ENTRY_W-1:0]  v_dn;
	logic                req_take, cfg_take, cfg_hit;
	logic [ORD_W-1:0]    new_min, new_pool;
	logic [LVL_W-1:0]    new_top;
	logic                free_ok;
	logic [SIZE_W-1:0]   free_sz;
	logic [SIZE_W-1:0]   tgt_sz;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] l,
		input logic [IDX_W-1:0] i);
		return ADDR_W'(l) * ADDR_W'(bba_pkg::LIST_DEPTH) + ADDR_W'(i);
	endfunction

	assign m_eff   = bba_pkg::eff_min(min_q);
	assign p_eff   = bba_pkg::eff_pool(min_q, pool_q);
	assign cap     = SIZE_W'(1) << p_eff;
	assign free_bytes = (used_q < cap) ? cap - used_q : '0;
	assign top_lvl = LVL_W'(p_eff - m_eff);
	assign lvl     = LVL_W'(ord_q - m_eff);
	assign lvl_dn  = LVL_W'(ord_q - m_eff - ORD_W'(1));
	assign len_sel = (state_q == S_SPLIT) ? lvl_dn : lvl;
	assign len_cur = len_q[len_sel];
	assign len_room = len_cur < LEN_W'(bba_pkg::LIST_DEPTH);
	assign idx_nx  = {1'b0, idx_q} + (LEN_W+1)'(1);
	assign v_dn    = {v_q[ENTRY_W-2:0], 1'b1};
	assign tgt_sz  = SIZE_W'(1) << tgt_q;
	assign free_sz = SIZE_W'(1) << ord_q;
	assign free_ok = (ord_q >= m_eff) && (ord_q <= p_eff) && ({1'b0, off_q} < cap) &&
		((off_q & OFF_W'((SIZE_W'(1) << ord_q) - SIZE_W'(1))) == '0);

	assign cfg_ready = (state_q == S_IDLE);
	assign cfg_take  = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_take &&
		(cfg_index == bba_pkg::REG_LO_ORD || cfg_index == bba_pkg::REG_POOL_ORDER);
	assign new_min   = (cfg_index == bba_pkg::REG_LO_ORD) ? cfg_data : min_q;
	assign new_pool  = (cfg_index == bba_pkg::REG_POOL_ORDER) ? cfg_data : pool_q;
	assign new_top   = LVL_W'(bba_pkg::eff_pool(new_min, new_pool) - bba_pkg::eff_min(new_min));

	assign req_stall = (state_q != S_IDLE) || cfg_valid;
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// RAM port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = addr_of(lvl, idx_q[IDX_W-1:0]);
		mem_raddr = addr_of(lvl, idx_q[IDX_W-1:0]);
		mem_wdata = v_q;
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = addr_of(top_lvl, '0);
				mem_wdata = '0;
			end
			S_A_FIND: begin
				mem_re    = (ord_q <= p_eff) && (len_cur != '0);
				mem_raddr = addr_of(lvl, '0);
			end
			S_RM_RD: begin
				mem_re    = idx_nx < (LEN_W+1)'(len_cur);
				mem_raddr = addr_of(lvl, idx_nx[IDX_W-1:0]);
			end
			S_RM_WR: begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q;
			end
			S_SPLIT: begin
				mem_we    = (ord_q > tgt_q) && len_room;
				mem_waddr = addr_of(lvl_dn, len_cur[IDX_W-1:0]);
				mem_wdata = v_dn;
			end
			S_F_RD: begin
				mem_re    = idx_q < len_cur;
			end
			S_F_APP: begin
				mem_we    = len_room;
				mem_waddr = addr_of(lvl, len_cur[IDX_W-1:0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			min_q       <= bba_pkg::LO_ORD_RST;
			pool_q      <= bba_pkg::POOL_ORDER_RST;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < bba_pkg::LEVELS; i++) begin
				len_q[i] <= (LVL_W'(i) == LVL_W'(bba_pkg::eff_pool(bba_pkg::LO_ORD_RST,
					bba_pkg::POOL_ORDER_RST) - bba_pkg::eff_min(bba_pkg::LO_ORD_RST)))
					? LEN_W'(1) : '0;
			end
		end else begin
			// the done state loads the next result itself
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (cfg_hit) begin
						min_q   <= new_min;
						pool_q  <= new_pool;
						used_q  <= '0;
						for (int i = 0; i < bba_pkg::LEVELS; i++) begin
							len_q[i] <= (LVL_W'(i) == new_top) ? LEN_W'(1) : '0;
						end
						state_q <= S_INIT;
					end else if (req_take) begin
						cmd_q  <= req.command;
						st_q   <= bba_pkg::ST_DONE;
						goff_q <= '0;
						gord_q <= '0;
						if (req.command == bba_pkg::CMD_ALLOC) begin
							req_q   <= (req.request_size < (SIZE_W'(1) << m_eff)) ?
								(SIZE_W'(1) << m_eff) : req.request_size;
							tgt_q   <= m_eff;
							state_q <= S_A_ORD;
						end else begin
							off_q   <= req.block_offset;
							ord_q   <= req.block_order;
							state_q <= S_F_CHK;
						end
					end
				end
				S_INIT: state_q <= S_IDLE;
				// round the size up to a power of two, one order a cycle
				S_A_ORD: begin
					if (tgt_q < ORD_W'(SIZE_W) && tgt_sz < req_q) tgt_q <= tgt_q + ORD_W'(1);
					else state_q <= S_A_CHK;
				end
				S_A_CHK: begin
					if (tgt_q > p_eff) begin
						st_q    <= bba_pkg::ST_TOO_LARGE;
						state_q <= S_DONE;
					end else if (req_q > free_bytes) begin
						st_q    <= bba_pkg::ST_NO_SPACE;
						state_q <= S_DONE;
					end else begin
						ord_q   <= tgt_q;
						state_q <= S_A_FIND;
					end
				end
				S_A_FIND: begin
					if (ord_q > p_eff) begin
						st_q    <= bba_pkg::ST_NO_SPACE;
						state_q <= S_DONE;
					end else if (len_cur == '0) begin
						ord_q <= ord_q + ORD_W'(1);
					end else begin
						state_q <= S_A_HEAD;
					end
				end
				S_A_HEAD: begin
					v_q     <= rdata_q;
					idx_q   <= '0;
					state_q <= S_RM_RD;
				end
				// remove entry idx_q: shift the tail down one place
				S_RM_RD: begin
					if (idx_nx < (LEN_W+1)'(len_cur)) begin
						state_q <= S_RM_WR;
					end else begin
						len_q[lvl] <= len_cur - LEN_W'(1);
						if (cmd_q == bba_pkg::CMD_ALLOC) begin
							state_q <= S_SPLIT;
						end else begin
							v_q     <= v_q >> 1;
							ord_q   <= ord_q + ORD_W'(1);
							state_q <= S_F_LVL;
						end
					end
				end
				S_RM_WR: begin
					idx_q   <= idx_nx[LEN_W-1:0];
					state_q <= S_RM_RD;
				end
				S_SPLIT: begin
					if (ord_q > tgt_q) begin
						if (len_room) len_q[lvl_dn] <= len_cur + LEN_W'(1);
						v_q   <= {v_q[ENTRY_W-2:0], 1'b0};
						ord_q <= ord_q - ORD_W'(1);
					end else begin
						used_q  <= used_q + tgt_sz;
						goff_q  <= OFF_W'(OFF_W'(v_q) << tgt_q);
						gord_q  <= tgt_q;
						state_q <= S_DONE;
					end
				end
				S_F_CHK: begin
					if (free_ok) begin
						used_q  <= (used_q > free_sz) ? used_q - free_sz : '0;
						v_q     <= ENTRY_W'(off_q >> ord_q);
						state_q <= S_F_LVL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_F_LVL: begin
					idx_q   <= '0;
					state_q <= (ord_q < p_eff) ? S_F_RD : S_F_APP;
				end
				S_F_RD: begin
					state_q <= (idx_q < len_cur) ? S_F_CMP : S_F_APP;
				end
				S_F_CMP: begin
					if (rdata_q == (v_q ^ ENTRY_W'(1))) begin
						state_q <= S_RM_RD;
					end else begin
						idx_q   <= idx_nx[LEN_W-1:0];
						state_q <= S_F_RD;
					end
				end
				S_F_APP: begin
					if (len_room) len_q[lvl] <= len_cur + LEN_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status         <= st_q;
						rsp_q.granted_offset <= goff_q;
						rsp_q.granted_order  <= gord_q;
						rsp_q.bytes_in_use   <= used_q;
						rsp_valid_q          <= 1'b1;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/bba_checker.sv =====
// ---------------------------------------------------------------------------
// Buddy block allocator checker
// Port-level properties of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "buddy_block_allocator_macros.svh"

module bba_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input bba_pkg::rsp_t                 rsp,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [bba_pkg::CFG_IDX_W-1:0] cfg_index
);

	`BBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result item changed while stalled")
	`BBA_ASSERT_NOW(a_status_code, rsp_valid, rsp.status != 2'd3, "unknown status code")
	`BBA_ASSERT_NOW(a_fail_no_grant, rsp_valid && rsp.status != bba_pkg::ST_DONE, rsp.granted_offset == '0 && rsp.granted_order == '0, "failed alloc carries a grant")
	`BBA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "took a second item while busy")
	`BBA_ASSERT_NEXT(a_busy_after_cfg, cfg_valid && cfg_ready && (cfg_index == bba_pkg::REG_LO_ORD || cfg_index == bba_pkg::REG_POOL_ORDER), req_stall, "no pool seeding after register write")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
